FILE: hw/rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

    // Line counter width and saturation value
    localparam int unsigned LINE_BITS = 20;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_FIRST = {{(LINE_BITS-1){1'b0}}, 1'b1};

    // Characters with a meaning to the splitter
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Result kinds
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_SQUOTE  = 2'd1,
        MODE_DQUOTE  = 2'd2,
        MODE_COMMENT = 2'd3
    } mode_t;

    // One result from the scanner, valid when has_result is set
    typedef struct packed {
        logic                 has_result;
        logic                 kind;
        logic [7:0]           ch_res;
        logic [LINE_BITS-1:0] line;
    } sts_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sts_scan.sv
`default_nettype none

// Scanner state and the per-byte decision. State advances when step is high.
module sts_scan
    import sts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_source,
    output sts_res_t        res
);

    mode_t                mode_reg, mode_next;
    logic [7:0]           prev_reg, prev_next;
    logic [LINE_BITS-1:0] line_count_reg, line_count_next;
    logic                 open_reg, open_next;

    logic                 is_nl;
    logic                 is_ws;
    logic [LINE_BITS-1:0] line_inc;
    logic [7:0]           closer;

    // Shared decodes
    always_comb
    begin
        is_nl    = (ch == CH_NL);
        is_ws    = (ch inside {CH_SPACE, CH_TAB, CH_NL});
        line_inc = (is_nl && (line_count_reg != LINE_MAX)) ?
                   line_count_reg + LINE_FIRST : line_count_reg;
        closer   = (mode_reg == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
    end

    // Next state
    always_comb
    begin
        mode_next       = mode_reg;
        prev_next       = ch;
        line_count_next = line_inc;
        open_next       = open_reg;
        if (end_of_source)
        begin
            mode_next       = MODE_NORMAL;
            prev_next       = 8'h00;
            line_count_next = LINE_FIRST;
            open_next       = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_SQUOTE, MODE_DQUOTE:
                begin
                    if (ch == closer && prev_reg != CH_BSLASH)
                        mode_next = MODE_NORMAL;
                    open_next = 1'b1;
                end
                MODE_COMMENT:
                begin
                    if (is_nl)
                        mode_next = MODE_NORMAL;
                end
                default:
                begin
                    if (ch == CH_HASH)
                    begin
                        mode_next = MODE_COMMENT;
                        prev_next = prev_reg;
                        open_next = 1'b0;
                    end
                    else if (ch == CH_DQUOTE)
                    begin
                        mode_next = MODE_DQUOTE;
                        open_next = 1'b1;
                    end
                    else if (ch == CH_SQUOTE)
                    begin
                        mode_next = MODE_SQUOTE;
                        open_next = 1'b1;
                    end
                    else if (is_ws)
                        open_next = 1'b0;
                    else
                        open_next = 1'b1;
                end
            endcase
        end
    end

    // Result for the current byte
    always_comb
    begin
        res            = '0;
        res.kind       = KIND_APPEND;
        if (end_of_source)
        begin
            res.has_result = open_reg;
            res.kind       = KIND_END;
            res.line       = line_count_reg;
        end
        else
        begin
            case (mode_reg)
                MODE_SQUOTE, MODE_DQUOTE:
                begin
                    res.has_result = 1'b1;
                    res.ch_res     = ch;
                end
                MODE_COMMENT:
                    res.has_result = 1'b0;
                default:
                begin
                    if (ch == CH_HASH || is_ws)
                    begin
                        res.has_result = open_reg;
                        res.kind       = KIND_END;
                        res.line       = line_inc;
                    end
                    else
                    begin
                        res.has_result = 1'b1;
                        res.ch_res     = ch;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            prev_reg       <= 8'h00;
            line_count_reg <= LINE_FIRST;
            open_reg       <= 1'b0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            prev_reg       <= prev_next;
            line_count_reg <= line_count_next;
            open_reg       <= open_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/source_token_splitter.sv
`default_nettype none

// Source token splitter.
// Input channel (in_valid/in_ready) carries one source byte ch per
// transaction, or an end_of_source marker that flushes the open token and
// returns the scanner to its start state (line 1, normal mode).
// Output channel (out_valid/out_ready) carries at most one result per input
// transaction: kind 0 appends ch_res to the current token, kind 1 ends the
// token and reports its line number on line.
// Throughput is one byte per cycle while the receiver keeps up: the byte is
// captured in an input register, decided against the scanner state once the
// output register has room, and the result lands in an output register.
// Bytes that give no result (whitespace between tokens, comment text) still
// pass through the stage at one per cycle unless the receiver stalls.
// When the receiver stalls, the output register holds its result and the
// stage holds the next byte; in_ready drops only while both are full.
// Reset (rst_n, asynchronous) empties both registers and puts the scanner
// in normal mode on line 1 with no open token.
module source_token_splitter
    import sts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [7:0]           ch,
    input  wire logic                 end_of_source,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic                 kind,
    output      logic [7:0]           ch_res,
    output      logic [LINE_BITS-1:0] line
);

    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           ch_reg;
    logic                 eos_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg;
    logic [7:0]           ch_res_reg;
    logic [LINE_BITS-1:0] line_reg;

    logic                 s1_advance;
    logic                 in_take;
    sts_res_t             res;

    // Stage advances once the output register has room
    always_comb
    begin
        s1_advance     = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready       = !s1_valid_reg || s1_advance;
        in_take        = in_valid && in_ready;
        s1_valid_next  = in_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        out_valid_next = (s1_advance && res.has_result) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_reg);
    end

    sts_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_advance),
        .ch            (ch_reg),
        .end_of_source (eos_reg),
        .res           (res)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg  <= ch;
            eos_reg <= end_of_source;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (s1_advance && res.has_result)
        begin
            kind_reg   <= res.kind;
            ch_res_reg <= res.ch_res;
            line_reg   <= res.line;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign ch_res    = ch_res_reg;
    assign line      = line_reg;

`ifndef SYNTHESIS
    // Input side stalls only while the stage is full and blocked
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a blocked stage");

    // A token end always reports a nonzero line
    a_end_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_END) |-> (line != '0 && ch_res == 8'h00))
        else $error("token end with bad payload");

    // Appends carry no line number
    a_append_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_APPEND) |-> (line == '0))
        else $error("append with nonzero line");

    // A result loaded while the receiver stalls must not be lost
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !s1_advance)
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_source_token_splitter.sv
module tb_source_token_splitter;
    import sts_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int RANDOM_ITEMS = 1250;

    // One expected output transaction
    typedef struct packed {
        logic                 kind;
        logic [7:0]           ch_res;
        logic [LINE_BITS-1:0] line;
    } tok_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           ch = 8'h00;
    logic                 end_of_source = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic [7:0]           ch_res;
    logic [LINE_BITS-1:0] line;

    // Scanner state as predicted from the accepted input
    mode_t                scan_mode = MODE_NORMAL;
    logic [7:0]           scan_prev = 8'h00;
    logic [LINE_BITS-1:0] scan_line = LINE_FIRST;
    logic                 scan_open = 1'b0;

    tok_result_t expected_tokens[$];
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent_count = 0;

    source_token_splitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ch            (ch),
        .end_of_source (end_of_source),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .ch_res        (ch_res),
        .line          (line)
    );

    always #5 clk = ~clk;

    // Receiver: random backpressure at the current stall rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Advance the predicted scanner by one accepted byte or end marker
    task automatic predict_scan(input logic [7:0] c, input logic e);
        tok_result_t r;
        logic        has;
        logic        to_comment;
        logic [7:0]  closer;
        r = '0;
        has = 1'b0;
        to_comment = 1'b0;
        if (e)
        begin
            if (scan_open)
            begin
                has = 1'b1;
                r.kind = KIND_END;
                r.line = scan_line;
            end
            scan_mode = MODE_NORMAL;
            scan_prev = 8'h00;
            scan_line = LINE_FIRST;
            scan_open = 1'b0;
        end
        else
        begin
            // line advances before the newline itself is handled
            if (c == CH_NL && scan_line != LINE_MAX)
                scan_line = scan_line + 1'b1;
            case (scan_mode)
                MODE_SQUOTE, MODE_DQUOTE:
                begin
                    closer = (scan_mode == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
                    if (c == closer && scan_prev != CH_BSLASH)
                        scan_mode = MODE_NORMAL;
                    has = 1'b1;
                    r.kind = KIND_APPEND;
                    r.ch_res = c;
                end
                MODE_COMMENT:
                begin
                    if (c == CH_NL)
                        scan_mode = MODE_NORMAL;
                end
                default:
                begin
                    if (c == CH_HASH)
                    begin
                        scan_mode = MODE_COMMENT;
                        to_comment = 1'b1;
                        if (scan_open)
                        begin
                            has = 1'b1;
                            r.kind = KIND_END;
                            r.line = scan_line;
                        end
                    end
                    else if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
                    begin
                        if (scan_open)
                        begin
                            has = 1'b1;
                            r.kind = KIND_END;
                            r.line = scan_line;
                        end
                    end
                    else
                    begin
                        if (c == CH_DQUOTE)
                            scan_mode = MODE_DQUOTE;
                        else if (c == CH_SQUOTE)
                            scan_mode = MODE_SQUOTE;
                        has = 1'b1;
                        r.kind = KIND_APPEND;
                        r.ch_res = c;
                    end
                end
            endcase
            // a '#' that opens a comment leaves the previous byte alone
            if (!to_comment)
                scan_prev = c;
        end
        if (has)
        begin
            scan_open = (r.kind == KIND_APPEND);
            expected_tokens = {expected_tokens, r};
        end
    endtask

    // Send one transaction, with random idle cycles in front of it
    task automatic send_item(input logic [7:0] c, input logic e);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_of_source <= e;
        do
            @(posedge clk);
        while (!in_ready);
        // comment text is swallowed, so it does not count as traffic
        if (e || scan_mode != MODE_COMMENT)
            sent_count++;
        predict_scan(c, e);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Token byte: printable, never a quote or a comment mark
    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c == CH_HASH || c == CH_DQUOTE || c == CH_SQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] separator();
        case ($urandom_range(2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    // One chunk of plausible source text, or noise
    task automatic send_fragment();
        int         pick;
        int         n;
        logic [7:0] q;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_item(word_byte(), 1'b0);
            send_item(separator(), 1'b0);
        end
        else if (pick < 50)
        begin
            q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
            send_item(q, 1'b0);
            n = $urandom_range(0, 10);
            repeat (n)
            begin
                case ($urandom_range(5))
                    0: c = CH_BSLASH;
                    1: c = q;
                    2: c = (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
                    3: c = separator();
                    default: c = 8'($urandom_range(255));
                endcase
                send_item(c, 1'b0);
            end
            send_item(q, 1'b0);
        end
        else if (pick < 60)
        begin
            send_item(CH_HASH, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                c = 8'($urandom_range(255));
                if (c == CH_NL)
                    c = CH_DQUOTE;
                send_item(c, 1'b0);
            end
            send_item(CH_NL, 1'b0);
        end
        else if (pick < 70)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(separator(), 1'b0);
        end
        else if (pick < 74)
        begin
            send_item(8'($urandom_range(255)), 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // Lowest and highest byte values, tab as a terminator
    task automatic test_byte_extremes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_TAB, 1'b0);
    endtask

    // Newline with and without an open token
    task automatic test_line_counting();
        send_text("\nx\n");
    endtask

    // '#' ends a token; a quote inside a comment does nothing
    task automatic test_comment();
        send_text("y#\"\n");
    endtask

    // Backslash before the opener, then an escaped quote inside the string
    task automatic test_escaped_quote();
        send_text("\\\" \\\"\" ");
    endtask

    // Single-quote string holding a newline, then '#' after the closing quote
    task automatic test_single_quote_string();
        send_text("'\n'#");
    endtask

    // End marker inside a comment, with an open token, and with nothing open
    task automatic test_end_of_source();
        send_item(8'h00, 1'b1);
        send_text("z");
        send_item(8'hFF, 1'b1);
        send_item(8'hA5, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        idle_pct = idle;
        stall_pct = stall;
        sent_count = 0;
        while (sent_count < count)
            send_fragment();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin
        tok_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind=%0d ch_res=%0h line=%0d",
                         $time, kind, ch_res, line);
                error_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("ch_res", 32'(want.ch_res), 32'(ch_res));
                check_field("line", 32'(want.line), 32'(line));
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_extremes();
        test_line_counting();
        test_comment();
        test_escaped_quote();
        test_single_quote_string();
        test_end_of_source();
        test_random_traffic(0, 0, RANDOM_ITEMS / 4);
        test_random_traffic(65, 0, RANDOM_ITEMS / 4);
        test_random_traffic(0, 65, RANDOM_ITEMS / 4);
        test_random_traffic(30, 30, RANDOM_ITEMS / 4);
        in_valid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/sts_pkg.sv
hw/rtl/sts_scan.sv
hw/rtl/source_token_splitter.sv
verif/tb_source_token_splitter.sv
